>>> src/gbh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbh_pkg
// Shared types and constants of the group boost hysteresis controller.
// ----------------------------------------------------------------------------
package gbh_pkg;

  localparam int LevelW     = 11;
  localparam int TimeW      = 64;
  localparam int GapW       = 32;
  localparam int IndexW     = 4;
  localparam int IndexSpan  = 2 ** IndexW;
  localparam int MaskW      = 16;
  localparam int CfgIndexW  = 3;
  localparam int CfgDataW   = 32;
  localparam int InDataW    = 80;
  localparam int OutDataW   = 72;
  localparam int QueueDepth = 2;
  localparam int GroupsDefault = 16;

  localparam logic [LevelW-1:0] LevelDisabled = 11'd1024;
  localparam logic [LevelW-1:0] LevelBoost    = 11'd0;

  localparam logic [LevelW-1:0] UpLevelReset   = LevelDisabled;
  localparam logic [LevelW-1:0] DownLevelReset = LevelDisabled;
  localparam logic [GapW-1:0]   MinGapReset    = 32'd16000000;
  localparam logic [GapW-1:0]   RetainReset    = 32'd16000000;
  localparam logic [MaskW-1:0]  MaskReset      = 16'd0;

  localparam logic [CfgIndexW-1:0] RegUpLevel   = 3'd0;
  localparam logic [CfgIndexW-1:0] RegDownLevel = 3'd1;
  localparam logic [CfgIndexW-1:0] RegMinGap    = 3'd2;
  localparam logic [CfgIndexW-1:0] RegRetain    = 3'd3;
  localparam logic [CfgIndexW-1:0] RegGroupMask = 3'd4;

  localparam logic CmdDecide = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  typedef struct packed {
    logic [LevelW-1:0] up_level;
    logic [LevelW-1:0] down_level;
    logic [GapW-1:0]   min_gap_ns;
    logic [GapW-1:0]   retain_ns;
    logic [MaskW-1:0]  group_enable_mask;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic              in_range;
    logic [IndexW-1:0] group_index;
    logic [TimeW-1:0]  now_time;
    logic [LevelW-1:0] avg_load;
  } item_t;

  typedef struct packed {
    logic             boosted;
    logic             group_active;
    logic             decision_made;
    logic [TimeW-1:0] activation_time;
  } result_t;

endpackage

>>> src/gbh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbh_front
// Input stage: takes a transaction, unpacks and classifies it, and hands it
// to the queue.
// ----------------------------------------------------------------------------
module gbh_front #(
  parameter int GROUPS = gbh_pkg::GroupsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [gbh_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic                         s_axis_tuser_i,
  input  logic                         full_i,
  output logic                         push_o,
  output gbh_pkg::item_t               item_o
);

  localparam logic [31:0] GroupsW = 32'(GROUPS);
  localparam int NowLo  = gbh_pkg::IndexW;
  localparam int LoadLo = gbh_pkg::IndexW + gbh_pkg::TimeW;

  logic           valid_q, valid_d;
  gbh_pkg::item_t item_q;
  gbh_pkg::item_t item_d;
  logic           accept;

  assign push_o          = valid_q && !full_i;
  assign s_axis_tready_o = !valid_q || !full_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign item_o          = item_q;

  always_comb begin
    item_d.cmd         = s_axis_tuser_i;
    item_d.group_index = s_axis_tdata_i[gbh_pkg::IndexW-1:0];
    item_d.now_time    = s_axis_tdata_i[NowLo +: gbh_pkg::TimeW];
    item_d.avg_load    = s_axis_tdata_i[LoadLo +: gbh_pkg::LevelW];
    item_d.in_range    = 32'(item_d.group_index) < GroupsW;
  end

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

>>> src/gbh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbh_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module gbh_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gbh_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output gbh_pkg::item_t item_o
);

  localparam int Depth = gbh_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(Depth);

  gbh_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = count_q == DepthC;
  assign empty_o = count_q == '0;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (32'(wr_ptr_q) == Depth - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (32'(rd_ptr_q) == Depth - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> src/gbh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbh_back
// Execution stage: reads the group record, applies the gates and the
// hysteresis rule, writes the record back and registers the result.
// ----------------------------------------------------------------------------
module gbh_back #(
  parameter int GROUPS = gbh_pkg::GroupsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbh_pkg::cfg_t    cfg_i,
  input  logic             empty_i,
  input  gbh_pkg::item_t   item_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output gbh_pkg::result_t result_o
);

  localparam int Depth = (GROUPS < gbh_pkg::IndexSpan) ? GROUPS : gbh_pkg::IndexSpan;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int TW    = gbh_pkg::TimeW;

  localparam logic PhIdle = 1'b0;
  localparam logic PhExec = 1'b1;

  logic phase_q, phase_d;

  logic          act_q   [Depth];
  logic [TW-1:0] last_q  [Depth];
  logic [TW-1:0] low_q   [Depth];
  logic [TW-1:0] actat_q [Depth];

  gbh_pkg::item_t   it_q;
  logic             rec_act_q;
  logic [TW-1:0]    rec_last_q, rec_low_q, rec_actat_q;
  logic             out_valid_q, out_valid_d;
  gbh_pkg::result_t out_q, out_d;

  logic [IdxW-1:0] rd_idx, wr_idx;
  logic            fire, disabled, boost, enabled, gap_ok, expired, decide;
  logic [TW:0]     gap_diff, hold_diff;
  logic            new_act;
  logic [TW-1:0]   new_last, new_low, new_actat;

  assign rd_idx = item_i.group_index[IdxW-1:0];
  assign wr_idx = it_q.group_index[IdxW-1:0];
  assign pop_o  = (phase_q == PhIdle) && !empty_i;
  assign fire   = (phase_q == PhExec) && (!out_valid_q || m_ready_i);

  assign m_valid_o = out_valid_q;
  assign result_o  = out_q;

  always_comb begin
    disabled  = cfg_i.up_level == gbh_pkg::LevelDisabled;
    boost     = cfg_i.up_level == gbh_pkg::LevelBoost;
    enabled   = cfg_i.group_enable_mask[it_q.group_index];
    gap_diff  = {1'b0, it_q.now_time} - {1'b0, rec_last_q};
    gap_ok    = !gap_diff[TW] && (gap_diff[TW-1:0] >= TW'(cfg_i.min_gap_ns));
    hold_diff = {1'b0, rec_last_q} - {1'b0, rec_low_q};
    expired   = !hold_diff[TW] && (hold_diff[TW-1:0] > TW'(cfg_i.retain_ns));
    decide    = (it_q.cmd == gbh_pkg::CmdDecide) && it_q.in_range && !disabled &&
                enabled && gap_ok;

    new_act   = rec_act_q;
    new_low   = rec_low_q;
    new_actat = rec_actat_q;
    new_last  = it_q.now_time;
    if (boost) begin
      new_act   = 1'b1;
      new_low   = '0;
      new_actat = it_q.now_time;
    end else begin
      if (!rec_act_q) begin
        if (it_q.avg_load > cfg_i.up_level) begin
          new_act = 1'b1;
        end
      end else if (it_q.avg_load < cfg_i.down_level) begin
        if (rec_low_q == '0) begin
          new_low = rec_last_q;
        end else if (expired) begin
          new_low = '0;
          new_act = 1'b0;
        end
      end else begin
        new_low = '0;
      end
      if (new_act != rec_act_q) begin
        new_actat = new_act ? it_q.now_time : '0;
      end
    end

    out_d.boosted         = (it_q.cmd == gbh_pkg::CmdQuery) && it_q.in_range && !disabled &&
                            enabled && (boost || rec_act_q);
    out_d.decision_made   = decide;
    out_d.group_active    = it_q.in_range && (decide ? new_act : rec_act_q);
    out_d.activation_time = !it_q.in_range ? '0 : (decide ? new_actat : rec_actat_q);
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PhIdle: begin
        if (pop_o) begin
          phase_d = PhExec;
        end
      end
      PhExec: begin
        if (fire) begin
          phase_d = PhIdle;
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  always_comb begin
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        act_q[i]   <= 1'b0;
        last_q[i]  <= '0;
        low_q[i]   <= '0;
        actat_q[i] <= '0;
      end
    end else if (fire && decide) begin
      act_q[wr_idx]   <= new_act;
      last_q[wr_idx]  <= new_last;
      low_q[wr_idx]   <= new_low;
      actat_q[wr_idx] <= new_actat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      it_q        <= item_i;
      rec_act_q   <= act_q[rd_idx];
      rec_last_q  <= last_q[rd_idx];
      rec_low_q   <= low_q[rd_idx];
      rec_actat_q <= actat_q[rd_idx];
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

endmodule

>>> src/group_boost_hysteresis_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_boost_hysteresis_controller_top
// Per-group activation controller with up/down hysteresis and retain timer.
// ----------------------------------------------------------------------------
// Items arrive on the s_axis channel: tuser carries the command (decide or
// query), tdata the group index, the time and the averaged load. Every item
// yields exactly one result transaction on the m_axis channel.
// Configuration registers are written through cfg_we_i, cfg_index_i and
// cfg_wdata_i; the user must write them only while the block is idle, as
// the block itself does not enforce it. An accepted item is registered in
// the input stage, then queued, then read from the queue with its group
// record fetched, then updated into the result register. The execution
// stage takes no new item until it is through with the last: it fetches a
// record while idle and, for a decision, writes it back as it registers.
// Reset clears every group to inactive with all timestamps zero and loads
// the register defaults; the block takes items in the first cycle after it.
// When the receiver stalls, the result register holds, the execution stage
// waits, the two-entry queue fills and then s_axis_tready falls.
// ----------------------------------------------------------------------------
module group_boost_hysteresis_controller_top #(
  parameter int GROUPS = gbh_pkg::GroupsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // group_index[3:0], now_time[67:4], avg_load[78:68], zero pad
  input  logic [gbh_pkg::InDataW-1:0]   s_axis_tdata,
  // cmd[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // boosted[0], group_active[1], decision_made[2], activation_time[66:3], pad
  output logic [gbh_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [gbh_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [gbh_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam int PadW = gbh_pkg::OutDataW - gbh_pkg::TimeW - 3;

  gbh_pkg::cfg_t    cfg_q;
  gbh_pkg::item_t   front_item, queue_item;
  gbh_pkg::result_t result;
  logic             push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.up_level          <= gbh_pkg::UpLevelReset;
      cfg_q.down_level        <= gbh_pkg::DownLevelReset;
      cfg_q.min_gap_ns        <= gbh_pkg::MinGapReset;
      cfg_q.retain_ns         <= gbh_pkg::RetainReset;
      cfg_q.group_enable_mask <= gbh_pkg::MaskReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gbh_pkg::RegUpLevel:   cfg_q.up_level          <= cfg_wdata_i[gbh_pkg::LevelW-1:0];
        gbh_pkg::RegDownLevel: cfg_q.down_level        <= cfg_wdata_i[gbh_pkg::LevelW-1:0];
        gbh_pkg::RegMinGap:    cfg_q.min_gap_ns        <= cfg_wdata_i[gbh_pkg::GapW-1:0];
        gbh_pkg::RegRetain:    cfg_q.retain_ns         <= cfg_wdata_i[gbh_pkg::GapW-1:0];
        gbh_pkg::RegGroupMask: cfg_q.group_enable_mask <= cfg_wdata_i[gbh_pkg::MaskW-1:0];
        default: ;
      endcase
    end
  end

  gbh_front #(
    .GROUPS (GROUPS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .full_i          (full),
    .push_o          (push),
    .item_o          (front_item)
  );

  gbh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (queue_item)
  );

  gbh_back #(
    .GROUPS (GROUPS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .empty_i   (empty),
    .item_i    (queue_item),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .result_o  (result)
  );

  assign m_axis_tdata = {{PadW{1'b0}}, result.activation_time, result.decision_made,
                         result.group_active, result.boosted};

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("push into a full queue");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop from an empty queue");

  a_inactive_time_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !result.group_active) |-> (result.activation_time == '0))
    else $error("inactive group reports a nonzero activation time");

  a_made_not_boosted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(result.decision_made && result.boosted))
    else $error("result is both a decision and a query answer");

endmodule

>>> sim/group_boost_hysteresis_controller_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_boost_hysteresis_controller_top_tb
// Self-checking bench for the group boost hysteresis controller.
// ----------------------------------------------------------------------------
// A short directed run covers the disable, enable-mask, minimum-gap, boost,
// countdown and expiry cases. After it come randomized phases under changing
// register settings, the extremes among them. Most items in these phases
// come in per-group runs, mostly decides, with steadily advancing time.
// A built-in model of the group records predicts every result transaction,
// and each one is compared field by field. The sender idles in bursts and
// the receiver stalls in patterns of its own.
// ----------------------------------------------------------------------------
module group_boost_hysteresis_controller_top_tb;

  localparam int LevelW    = gbh_pkg::LevelW;
  localparam int GapW      = gbh_pkg::GapW;
  localparam int MaskW     = gbh_pkg::MaskW;
  localparam int TimeW     = gbh_pkg::TimeW;
  localparam int IndexW    = gbh_pkg::IndexW;
  localparam int CfgIndexW = gbh_pkg::CfgIndexW;
  localparam int CfgDataW  = gbh_pkg::CfgDataW;
  localparam int InDataW   = gbh_pkg::InDataW;
  localparam int OutDataW  = gbh_pkg::OutDataW;

  localparam int CycleLimit  = 400000;
  localparam int PhaseItems  = 160;
  localparam int PhaseCount  = 10;
  localparam int GroupCount  = 16;

  class boost_verdict_board;
    logic [LevelW-1:0] up_lvl;
    logic [LevelW-1:0] down_lvl;
    logic [GapW-1:0]   gap_ns;
    logic [GapW-1:0]   hold_ns;
    logic [MaskW-1:0]  mask;
    logic              active_q [GroupCount];
    logic [TimeW-1:0]  last_t [GroupCount];
    logic [TimeW-1:0]  low_t [GroupCount];
    logic [TimeW-1:0]  act_t [GroupCount];
    gbh_pkg::result_t  verdict_q [$];
    int                errors;
    int                seen;

    function new();
      up_lvl   = gbh_pkg::UpLevelReset;
      down_lvl = gbh_pkg::DownLevelReset;
      gap_ns   = gbh_pkg::MinGapReset;
      hold_ns  = gbh_pkg::RetainReset;
      mask     = gbh_pkg::MaskReset;
      errors   = 0;
      seen     = 0;
      for (int i = 0; i < GroupCount; i++) begin
        active_q[i] = 1'b0;
        last_t[i]   = '0;
        low_t[i]    = '0;
        act_t[i]    = '0;
      end
    endfunction

    function void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        gbh_pkg::RegUpLevel:   up_lvl = data[LevelW-1:0];
        gbh_pkg::RegDownLevel: down_lvl = data[LevelW-1:0];
        gbh_pkg::RegMinGap:    gap_ns = data;
        gbh_pkg::RegRetain:    hold_ns = data;
        gbh_pkg::RegGroupMask: mask = data[MaskW-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function void note_item(logic cmd, logic [IndexW-1:0] g, logic [TimeW-1:0] now,
                            logic [LevelW-1:0] load);
      gbh_pkg::result_t r;
      logic             prev;
      logic             gap_ok;
      r = '0;
      if (cmd == gbh_pkg::CmdDecide) begin
        gap_ok = (now >= last_t[g]) && ((now - last_t[g]) >= {32'b0, gap_ns});
        if (up_lvl != gbh_pkg::LevelDisabled && mask[g] && gap_ok) begin
          r.decision_made = 1'b1;
          if (up_lvl == gbh_pkg::LevelBoost) begin
            active_q[g] = 1'b1;
            low_t[g]    = '0;
            act_t[g]    = now;
            last_t[g]   = now;
          end else begin
            prev = active_q[g];
            if (!active_q[g]) begin
              if (load > up_lvl) active_q[g] = 1'b1;
            end else if (load < down_lvl) begin
              if (low_t[g] == '0) begin
                low_t[g] = last_t[g];
              end else if (last_t[g] >= low_t[g] &&
                           (last_t[g] - low_t[g]) > {32'b0, hold_ns}) begin
                low_t[g]    = '0;
                active_q[g] = 1'b0;
              end
            end else begin
              low_t[g] = '0;
            end
            last_t[g] = now;
            if (active_q[g] != prev) act_t[g] = active_q[g] ? now : '0;
          end
        end
      end else if (up_lvl != gbh_pkg::LevelDisabled && mask[g]) begin
        r.boosted = (up_lvl == gbh_pkg::LevelBoost) || active_q[g];
      end
      r.group_active    = active_q[g];
      r.activation_time = act_t[g];
      verdict_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at result %0d: %s", seen, msg);
    endtask

    task check_result(logic [OutDataW-1:0] word);
      gbh_pkg::result_t want;
      if (verdict_q.size() == 0) begin
        report("result transaction with no item outstanding");
      end else begin
        want = verdict_q.pop_front();
        if (word[0] !== want.boosted)
          report($sformatf("boosted got %b want %b", word[0], want.boosted));
        if (word[1] !== want.group_active)
          report($sformatf("group_active got %b want %b", word[1], want.group_active));
        if (word[2] !== want.decision_made)
          report($sformatf("decision_made got %b want %b", word[2], want.decision_made));
        if (word[66:3] !== want.activation_time)
          report($sformatf("activation_time got %h want %h", word[66:3],
                           want.activation_time));
      end
      seen++;
    endtask
  endclass

  logic                 clk;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;

  boost_verdict_board sb;
  logic [TimeW-1:0]   t_now;
  int                 burst_left;
  int                 cycles = 0;
  int                 rx_mode = 0;
  int                 rx_left = 0;
  int                 rx_pos = 0;
  logic [7:0]         rx_pat = 8'hFF;

  group_boost_hysteresis_controller_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("group_boost_hysteresis_controller_top verification failed");
      $finish;
    end
  end

  // The receiver switches between stall styles, picking a new style and pattern when its countdown runs out.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 96);
      rx_pat  = 8'($urandom);
    end
    rx_left--;
    rx_pos++;
    case (rx_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = 1'($urandom_range(0, 1));
      2: m_axis_tready = rx_pat[rx_pos % 8] | (rx_pat == 8'h00);
      default: m_axis_tready = ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  task automatic send_item(logic cmd, logic [IndexW-1:0] g, logic [TimeW-1:0] now,
                           logic [LevelW-1:0] load);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tdata  = {1'b0, load, now, g};
    s_axis_tuser  = cmd;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(cmd, g, now, load);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    sb.write_reg(idx, data);
  endtask

  task automatic load_settings(int up, int down, logic [GapW-1:0] gap, logic [GapW-1:0] hold,
                               logic [MaskW-1:0] mask);
    drain_results();
    write_reg(gbh_pkg::RegUpLevel, CfgDataW'(up));
    write_reg(gbh_pkg::RegDownLevel, CfgDataW'(down));
    write_reg(gbh_pkg::RegMinGap, gap);
    write_reg(gbh_pkg::RegRetain, hold);
    write_reg(gbh_pkg::RegGroupMask, {16'b0, mask});
    @(negedge clk);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [LevelW-1:0] pick_load();
    int up;
    int down;
    up   = sb.up_lvl;
    down = sb.down_lvl;
    case ($urandom_range(0, 4))
      0: return (up < 1024) ? LevelW'($urandom_range(up + 1, 1024)) : LevelW'(1024);
      1: return (down > 0) ? LevelW'($urandom_range(0, down - 1)) : LevelW'(0);
      2: return LevelW'($urandom_range(0, 1024));
      3: return LevelW'(up);
      default: return LevelW'(down);
    endcase
  endfunction

  function automatic logic [TimeW-1:0] pick_step();
    int unsigned spread;
    if ($urandom_range(0, 9) == 0)
      return (sb.gap_ns > 0) ? TimeW'($urandom_range(0, sb.gap_ns - 1)) : '0;
    spread = (sb.hold_ns > 20000) ? 20000 : sb.hold_ns + 16;
    return TimeW'(sb.gap_ns) + TimeW'($urandom_range(0, spread));
  endfunction

  task automatic run_random(int n_items);
    int               sent;
    int               len;
    logic [IndexW-1:0] g;
    logic [TimeW-1:0]  stale;
    sent = 0;
    while (sent < n_items) begin
      g = IndexW'($urandom_range(0, GroupCount - 1));
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: send_item(gbh_pkg::CmdQuery, g, {$urandom, $urandom},
                       LevelW'($urandom_range(0, 1024)));
          1: begin
            stale = (t_now > 1000) ? t_now - $urandom_range(0, 1000) : t_now;
            send_item(gbh_pkg::CmdDecide, g, stale, pick_load());
          end
          default: send_item(gbh_pkg::CmdDecide, g, t_now, LevelW'($urandom_range(0, 1024)));
        endcase
        sent++;
      end else begin
        len = $urandom_range(2, 10);
        for (int j = 0; j < len && sent < n_items; j++) begin
          if ($urandom_range(0, 3) == 0) begin
            send_item(gbh_pkg::CmdQuery, g, t_now, LevelW'($urandom_range(0, 1024)));
          end else begin
            t_now = t_now + pick_step();
            send_item(gbh_pkg::CmdDecide, g, t_now, pick_load());
          end
          sent++;
        end
      end
    end
  endtask

  task automatic pick_settings(int k);
    int up;
    up = $urandom_range(1, 1023);
    case (k % 8)
      0: load_settings(up, $urandom_range(0, 1024), $urandom_range(0, 3000),
                       $urandom_range(0, 8000), MaskW'($urandom));
      1: load_settings(0, $urandom_range(0, 1024), $urandom_range(0, 2000),
                       $urandom_range(0, 8000), MaskW'($urandom));
      2: load_settings(1024, $urandom_range(0, 1024), 0, $urandom_range(0, 100), 16'hFFFF);
      3: load_settings(1023, 1024, 0, 0, 16'hFFFF);
      4: load_settings(1, 0, $urandom_range(0, 500), $urandom_range(0, 3000),
                       MaskW'($urandom));
      5: load_settings(up, $urandom_range(0, 1024), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      6: load_settings(up, $urandom_range(0, 1024), $urandom_range(0, 2000),
                       $urandom_range(0, 3000), 16'h0000);
      default: begin
        load_settings(up, $urandom_range(0, up), $urandom_range(0, 500),
                      $urandom_range(0, 3000), 16'hFFFF);
        t_now = {2'b10, 30'($urandom), 32'($urandom)};
      end
    endcase
  endtask

  initial begin
    sb            = new();
    burst_left    = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = gbh_pkg::CmdDecide;
    cfg_we_i      = 1'b0;
    cfg_index_i   = gbh_pkg::RegUpLevel;
    cfg_wdata_i   = '0;
    t_now         = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // Reset settings leave the controller disabled.
    send_item(gbh_pkg::CmdQuery, 4'd0, '0, 11'd0);
    send_item(gbh_pkg::CmdDecide, 4'd15, '1, 11'd1024);
    send_item(gbh_pkg::CmdQuery, 4'd15, '1, 11'd1024);

    // Boost mode with group 9 left out of the mask.
    load_settings(0, 1024, 0, 0, 16'hFDFF);
    send_item(gbh_pkg::CmdDecide, 4'd3, 64'd0, 11'd0);
    send_item(gbh_pkg::CmdDecide, 4'd3, 64'd5, 11'd1024);
    send_item(gbh_pkg::CmdQuery, 4'd5, 64'd5, 11'd0);
    send_item(gbh_pkg::CmdDecide, 4'd9, 64'd10, 11'd1024);
    send_item(gbh_pkg::CmdQuery, 4'd9, 64'd10, 11'd0);

    // Hysteresis: activation, a countdown that cannot start from time zero,
    // a countdown cancelled by normal load, and a countdown that expires.
    load_settings(500, 300, 0, 10, 16'hFDFF);
    send_item(gbh_pkg::CmdDecide, 4'd4, 64'd0, 11'd1024);
    send_item(gbh_pkg::CmdDecide, 4'd4, 64'd50, 11'd0);
    send_item(gbh_pkg::CmdDecide, 4'd4, 64'd60, 11'd0);
    send_item(gbh_pkg::CmdDecide, 4'd1, 64'd100, 11'd501);
    send_item(gbh_pkg::CmdDecide, 4'd1, 64'd110, 11'd200);
    send_item(gbh_pkg::CmdDecide, 4'd1, 64'd120, 11'd300);
    send_item(gbh_pkg::CmdDecide, 4'd1, 64'd130, 11'd299);
    send_item(gbh_pkg::CmdDecide, 4'd1, 64'd140, 11'd0);
    send_item(gbh_pkg::CmdDecide, 4'd1, 64'd150, 11'd0);
    send_item(gbh_pkg::CmdDecide, 4'd1, 64'd160, 11'd500);
    send_item(gbh_pkg::CmdQuery, 4'd1, 64'd160, 11'd0);
    send_item(gbh_pkg::CmdQuery, 4'd3, 64'd160, 11'd0);

    // Minimum interval between decisions.
    load_settings(500, 300, 1000, 10, 16'hFDFF);
    send_item(gbh_pkg::CmdDecide, 4'd1, 64'd1200, 11'd1024);
    send_item(gbh_pkg::CmdDecide, 4'd1, 64'd1500, 11'd0);
    send_item(gbh_pkg::CmdQuery, 4'd1, 64'd1500, 11'd0);

    t_now = 64'd2000;
    for (int k = 0; k < PhaseCount; k++) begin
      pick_settings(k);
      if (k == 0) begin
        run_random(PhaseItems / 2);
        drain_results();
        run_random(PhaseItems - PhaseItems / 2);
      end else begin
        run_random(PhaseItems);
      end
    end
    send_item(gbh_pkg::CmdDecide, 4'd7, '1, 11'd1024);
    send_item(gbh_pkg::CmdQuery, 4'd7, '1, 11'd1024);

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("group_boost_hysteresis_controller_top verification clean");
    end else begin
      $display("group_boost_hysteresis_controller_top verification failed");
    end
    $finish;
  end

endmodule
